// ===== sv/aabb_frustum_plane_test_assert.svh =====
// assertion helpers used by afpt_pipe_ctrl
`ifndef AABB_FRUSTUM_PLANE_TEST_ASSERT_SVH
`define AABB_FRUSTUM_PLANE_TEST_ASSERT_SVH

// same-cycle implication, checked outside reset
`define AFPT_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define AFPT_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/afpt_pkg.sv =====
`default_nettype none

package afpt_pkg;

    localparam int MAX_PLANES   = 6;
    localparam int STAGE_COUNT  = 4;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int SEL_W        = 6;

    // register indexes on the config channel
    localparam logic [CFG_INDEX_W-1:0] REG_CORNER_SELECT = 3'd6;

    typedef logic signed [15:0] coord_t;

    typedef enum logic [1:0] {
        VERDICT_OUTSIDE   = 2'd0,
        VERDICT_INSIDE    = 2'd1,
        VERDICT_INTERSECT = 2'd2
    } verdict_t;

    typedef struct packed {
        coord_t                  min_x;
        coord_t                  min_y;
        coord_t                  min_z;
        coord_t                  max_x;
        coord_t                  max_y;
        coord_t                  max_z;
        logic [MAX_PLANES-1:0]   active_planes;
    } box_t;

    typedef struct packed {
        verdict_t                verdict;
        logic [MAX_PLANES-1:0]   straddled_planes;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0]  index;
        logic [CFG_DATA_W-1:0]   value;
    } cfg_write_t;

    // load enables, one per pipeline register stage
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

    // per-plane outcome after the compare stage
    typedef struct packed {
        logic outside;
        logic straddle;
    } lane_flags_t;

endpackage

`default_nettype wire

// ===== sv/afpt_stream_if.sv =====
`default_nettype none

interface afpt_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// ===== sv/afpt_cfg_regs.sv =====
`default_nettype none

module afpt_cfg_regs #(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    afpt_stream_if.sink                        cfg,
    output logic [afpt_pkg::CFG_DATA_W-1:0]    plane_word [PLANE_COUNT],
    output logic [afpt_pkg::SEL_W*PLANE_COUNT-1:0] corner_select
);
    import afpt_pkg::*;

    localparam int SELECT_W = SEL_W * PLANE_COUNT;

    logic                  wr_en;
    logic [SELECT_W-1:0]   select_reg;
    logic [SELECT_W-1:0]   select_next;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
        logic [CFG_DATA_W-1:0] plane_reg;
        logic [CFG_DATA_W-1:0] plane_next;

        always_comb
        begin
            plane_next = plane_reg;
            if (wr_en && cfg.data.index == CFG_INDEX_W'(g))
            begin
                plane_next = cfg.data.value;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                plane_reg <= '0;
            end
            else
            begin
                plane_reg <= plane_next;
            end
        end

        assign plane_word[g] = plane_reg;
    end

    // bits above the stored planes are dropped
    always_comb
    begin
        select_next = select_reg;
        if (wr_en && cfg.data.index == REG_CORNER_SELECT)
        begin
            select_next = cfg.data.value[SELECT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg <= '0;
        end
        else
        begin
            select_reg <= select_next;
        end
    end

    assign corner_select = select_reg;

endmodule

`default_nettype wire

// ===== sv/afpt_pipe_ctrl.sv =====
`default_nettype none

`include "aabb_frustum_plane_test_assert.svh"

module afpt_pipe_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output afpt_pkg::stage_en_t  en
);
    import afpt_pkg::*;

    logic [STAGE_COUNT-1:0] valid_reg;
    logic [STAGE_COUNT-1:0] valid_next;
    logic [STAGE_COUNT-1:0] stage_ready;

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        stage_ready[STAGE_COUNT-1] = !valid_reg[STAGE_COUNT-1] || out_ready;
        for (int k = STAGE_COUNT - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_ready[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < STAGE_COUNT; k++)
        begin
            if (stage_ready[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[STAGE_COUNT-1];
    assign en.s1     = stage_ready[0];
    assign en.s2     = stage_ready[1];
    assign en.s3     = stage_ready[2];
    assign en.s4     = stage_ready[3];

    `AFPT_ASSERT_IMPL(a_empty_tail_takes_request, clk, rst_n, !valid_reg[STAGE_COUNT-1], in_ready, "input blocked with empty output stage")
    `AFPT_ASSERT_NEXT(a_first_stage_moves_on, clk, rst_n, valid_reg[0] && en.s2, valid_reg[1], "request lost between first and second stage")
    `AFPT_ASSERT_IMPL(a_full_stall_blocks_input, clk, rst_n, (&valid_reg) && !out_ready, !in_ready, "request taken into a full stalled pipeline")

endmodule

`default_nettype wire

// ===== sv/afpt_plane_lane.sv =====
`default_nettype none

module afpt_plane_lane (
    input  wire logic                           clk,
    input  wire afpt_pkg::stage_en_t            en,
    input  wire afpt_pkg::box_t                 box,
    input  wire logic                           act,
    input  wire logic [afpt_pkg::CFG_DATA_W-1:0] plane,
    input  wire logic [afpt_pkg::SEL_W-1:0]     sel,
    output afpt_pkg::lane_flags_t               flags
);
    import afpt_pkg::*;

    logic signed [15:0] nrm_a, nrm_b, nrm_c, ofs_d;
    logic signed [15:0] fx, fy, fz, sx, sy, sz;

    logic signed [31:0] prod_first_next [3];
    logic signed [31:0] prod_second_next [3];
    logic signed [31:0] prod_first_reg [3];
    logic signed [31:0] prod_second_reg [3];
    logic               act1_reg;

    logic signed [33:0] dot_first_next, dot_second_next;
    logic signed [33:0] dot_first_reg, dot_second_reg;
    logic               act2_reg;

    logic signed [34:0] ofs_scaled;
    logic signed [34:0] dist_first, dist_second;
    lane_flags_t        flags_next;
    lane_flags_t        flags_reg;

    // plane words must hold still while requests are in flight; the lane does not check this
    assign nrm_a = $signed(plane[15:0]);
    assign nrm_b = $signed(plane[31:16]);
    assign nrm_c = $signed(plane[47:32]);
    assign ofs_d = $signed(plane[63:48]);

    // stage 1: corner pick and products
    assign fx = sel[0] ? box.max_x : box.min_x;
    assign fy = sel[1] ? box.max_y : box.min_y;
    assign fz = sel[2] ? box.max_z : box.min_z;
    assign sx = sel[3] ? box.max_x : box.min_x;
    assign sy = sel[4] ? box.max_y : box.min_y;
    assign sz = sel[5] ? box.max_z : box.min_z;

    always_comb
    begin
        prod_first_next[0]  = nrm_a * fx;
        prod_first_next[1]  = nrm_b * fy;
        prod_first_next[2]  = nrm_c * fz;
        prod_second_next[0] = nrm_a * sx;
        prod_second_next[1] = nrm_b * sy;
        prod_second_next[2] = nrm_c * sz;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_first_reg  <= prod_first_next;
            prod_second_reg <= prod_second_next;
            act1_reg        <= act;
        end
    end

    // stage 2: dot products
    assign dot_first_next  = 34'(prod_first_reg[0]) + 34'(prod_first_reg[1])
                           + 34'(prod_first_reg[2]);
    assign dot_second_next = 34'(prod_second_reg[0]) + 34'(prod_second_reg[1])
                           + 34'(prod_second_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            dot_first_reg  <= dot_first_next;
            dot_second_reg <= dot_second_next;
            act2_reg       <= act1_reg;
        end
    end

    // stage 3: behind test, dot + d*2^14 < 0
    assign ofs_scaled  = {{5{ofs_d[15]}}, ofs_d, 14'b0};
    assign dist_first  = 35'(dot_first_reg) + ofs_scaled;
    assign dist_second = 35'(dot_second_reg) + ofs_scaled;

    always_comb
    begin
        flags_next.outside  = act2_reg && dist_first[34];
        flags_next.straddle = act2_reg && dist_second[34];
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire

// ===== sv/afpt_resolve.sv =====
`default_nettype none

module afpt_resolve #(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic                   clk,
    input  wire afpt_pkg::stage_en_t    en,
    input  wire afpt_pkg::lane_flags_t  flags [PLANE_COUNT],
    output afpt_pkg::result_t           result
);
    import afpt_pkg::*;

    logic                  any_outside;
    logic [MAX_PLANES-1:0] crossed;
    result_t               result_next;
    result_t               result_reg;

    always_comb
    begin
        any_outside = 1'b0;
        crossed     = '0;
        for (int i = 0; i < PLANE_COUNT; i++)
        begin
            any_outside = any_outside || flags[i].outside;
            crossed[i]  = flags[i].straddle;
        end

        if (any_outside)
        begin
            result_next.verdict          = VERDICT_OUTSIDE;
            result_next.straddled_planes = '0;
        end
        else if (crossed != '0)
        begin
            result_next.verdict          = VERDICT_INTERSECT;
            result_next.straddled_planes = crossed;
        end
        else
        begin
            result_next.verdict          = VERDICT_INSIDE;
            result_next.straddled_planes = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== sv/aabb_frustum_plane_test.sv =====
// channel   dir   payload                                   request taken when
// cfg       in    index (3b), value (64b)                   cfg.valid & cfg.ready
// box       in    min/max x,y,z (16b signed), active (6b)   box.valid & box.ready
// result    out   verdict (2b), straddled_planes (6b)       result.valid & result.ready
//
// one box per cycle sustained while result.ready holds
// stages: corner pick + multiply, dot sum, offset add + sign, verdict register
// the multiply stage (two 16x16 products per axis per plane) sets the clock
// rst_n clears the valid bits and all plane and select registers to zero
// a stalled result holds the tail; empty stages ahead of it keep filling
// cfg is always ready; write it only while no request is in flight, unchecked here
`default_nettype none

module aabb_frustum_plane_test #(
    parameter int PLANE_COUNT = 6
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    afpt_stream_if.sink     cfg,
    afpt_stream_if.sink     box,
    afpt_stream_if.source   result
);
    import afpt_pkg::*;

    // plane registers and the corner pick bits for each plane
    logic [CFG_DATA_W-1:0]        plane_word [PLANE_COUNT];
    logic [SEL_W*PLANE_COUNT-1:0] corner_select;

    // shared load enables for every lane and the verdict stage
    stage_en_t                    en;
    lane_flags_t                  flags [PLANE_COUNT];
    result_t                      result_data;

    afpt_cfg_regs #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .plane_word    (plane_word),
        .corner_select (corner_select)
    );

    // valid bits travel alongside the lane data
    afpt_pipe_ctrl u_pipe_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (box.valid),
        .in_ready  (box.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .en        (en)
    );

    // one lane per plane; active bits above the plane count are dropped here
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
        afpt_plane_lane u_lane (
            .clk   (clk),
            .en    (en),
            .box   (box.data),
            .act   (box.data.active_planes[g]),
            .plane (plane_word[g]),
            .sel   (corner_select[SEL_W*g +: SEL_W]),
            .flags (flags[g])
        );
    end

    // any active plane with its first corner behind it makes the box outside
    afpt_resolve #(
        .PLANE_COUNT (PLANE_COUNT)
    ) u_resolve (
        .clk    (clk),
        .en     (en),
        .flags  (flags),
        .result (result_data)
    );

    assign result.data = result_data;

endmodule

`default_nettype wire
